/* sv/tea_pkg.sv */
package tea_pkg;

  localparam int unsigned ROUNDS = 32;
  localparam int unsigned STAGES = 2 * ROUNDS;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned KEY_INDEX_W = 2;

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

  localparam logic [KEY_INDEX_W-1:0] KEY_WORD_ZERO  = 2'd0;
  localparam logic [KEY_INDEX_W-1:0] KEY_WORD_ONE   = 2'd1;
  localparam logic [KEY_INDEX_W-1:0] KEY_WORD_TWO   = 2'd2;
  localparam logic [KEY_INDEX_W-1:0] KEY_WORD_THREE = 2'd3;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } tea_op_t;

  typedef struct packed {
    tea_op_t           opcode;
    logic [WORD_W-1:0] block_left;
    logic [WORD_W-1:0] block_right;
  } tea_request_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_left;
    logic [WORD_W-1:0] result_right;
  } tea_result_t;

  typedef struct packed {
    logic [WORD_W-1:0] k0;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] k2;
    logic [WORD_W-1:0] k3;
  } tea_key_t;

  function automatic logic [WORD_W-1:0] round_sum(input int unsigned n);
    logic [63:0] prod;
    prod = 64'(n) * 64'(TEA_DELTA);
    return prod[WORD_W-1:0];
  endfunction

endpackage

/* sv/tea_key_regs.sv */
module tea_key_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [tea_pkg::KEY_INDEX_W-1:0]       cfg_index,
  input  logic [tea_pkg::WORD_W-1:0]            cfg_data,
  output tea_pkg::tea_key_t                     key
);

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        tea_pkg::KEY_WORD_ZERO:  key.k0 <= cfg_data;
        tea_pkg::KEY_WORD_ONE:   key.k1 <= cfg_data;
        tea_pkg::KEY_WORD_TWO:   key.k2 <= cfg_data;
        tea_pkg::KEY_WORD_THREE: key.k3 <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* sv/tea_half_round.sv */
module tea_half_round (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  tea_pkg::tea_request_t      in_data,
  input  tea_pkg::tea_key_t          key,
  input  logic [tea_pkg::WORD_W-1:0] enc_sum,
  input  logic [tea_pkg::WORD_W-1:0] dec_sum,
  input  logic                       upper_half,
  output logic                       out_valid,
  output tea_pkg::tea_request_t      out_data
);

  logic                       decrypt;
  logic                       update_left;
  logic [tea_pkg::WORD_W-1:0] x;
  logic [tea_pkg::WORD_W-1:0] ka;
  logic [tea_pkg::WORD_W-1:0] kb;
  logic [tea_pkg::WORD_W-1:0] sum;
  logic [tea_pkg::WORD_W-1:0] mix;
  logic [tea_pkg::WORD_W-1:0] target;
  logic [tea_pkg::WORD_W-1:0] updated;
  tea_pkg::tea_request_t      out_data_next;

  always_comb begin
    decrypt     = (in_data.opcode == tea_pkg::OP_DECRYPT);
    update_left = decrypt ? upper_half : !upper_half;
    x      = update_left ? in_data.block_right : in_data.block_left;
    target = update_left ? in_data.block_left : in_data.block_right;
    ka     = update_left ? key.k0 : key.k2;
    kb     = update_left ? key.k1 : key.k3;
    sum    = decrypt ? dec_sum : enc_sum;
    mix    = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    updated = decrypt ? (target - mix) : (target + mix);
    out_data_next = in_data;
    if (update_left) begin
      out_data_next.block_left = updated;
    end else begin
      out_data_next.block_right = updated;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_data_next;
  end

endmodule

/* sv/tea_block_cipher.sv */
// TEA block cipher, 64-bit block, 128-bit key. A block is taken whenever
// start is high; busy is always low, so one block may enter every cycle.
// Each block passes through a pipeline of one register stage per half-round,
// 2*32 = 64 stages. Its result is shown on result, marked by done, when it
// leaves the last stage register, for one cycle only. Results cannot
// be held off: the receiver must take each one in the cycle it is shown. Key
// words are written through cfg_write/cfg_index/cfg_data and must only change
// while no block is in flight.
module tea_block_cipher (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  tea_pkg::tea_request_t                 request,
  output logic                                  done,
  output tea_pkg::tea_result_t                  result,
  input  logic                                  cfg_write,
  input  logic [tea_pkg::KEY_INDEX_W-1:0]       cfg_index,
  input  logic [tea_pkg::WORD_W-1:0]            cfg_data
);

  tea_pkg::tea_key_t     key;
  logic                  valid [0:tea_pkg::STAGES];
  tea_pkg::tea_request_t data  [0:tea_pkg::STAGES];

  tea_key_regs u_key_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  assign busy     = 1'b0;
  assign valid[0] = start;
  assign data[0]  = request;

  for (genvar j = 0; j < tea_pkg::STAGES; j++) begin : g_stage
    tea_half_round u_half_round (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (valid[j]),
      .in_data    (data[j]),
      .key        (key),
      .enc_sum    (tea_pkg::round_sum(j / 2 + 1)),
      .dec_sum    (tea_pkg::round_sum(tea_pkg::ROUNDS - j / 2)),
      .upper_half (1'(j % 2)),
      .out_valid  (valid[j+1]),
      .out_data   (data[j+1])
    );
  end

  assign done                = valid[tea_pkg::STAGES];
  assign result.result_left  = data[tea_pkg::STAGES].block_left;
  assign result.result_right = data[tea_pkg::STAGES].block_right;

endmodule
